// ===== rtl/kpwq_pkg.sv =====
package kpwq_pkg;

  localparam int unsigned KEY_BITS  = 32;
  localparam int unsigned PRIO_BITS = 8;
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned CNT_BITS  = 5;

  typedef enum logic [2:0] {
    MODE_INSERT  = 3'd0,
    MODE_FIND    = 3'd1,
    MODE_PRESENT = 3'd2,
    MODE_BUMP    = 3'd3,
    MODE_COUNT   = 3'd4,
    MODE_DELETE  = 3'd5,
    MODE_CLEAR   = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // what every cell does at the execute edge
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_BUMP   = 2'd2,
    OP_DELETE = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [2:0]           mode;
    logic [KEY_BITS-1:0]  in_key;
    logic [PRIO_BITS-1:0] in_priority;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 found;
    logic [KEY_BITS-1:0]  out_key;
    logic [PRIO_BITS-1:0] out_priority;
    logic [CNT_BITS-1:0]  match_count;
    logic [CNT_BITS-1:0]  total_count;
  } rsp_t;

  typedef struct packed {
    cell_op_e             op;
    logic [KEY_BITS-1:0]  key;
    logic [PRIO_BITS-1:0] prio;
  } cell_cmd_t;

  // chain running left to right
  typedef struct packed {
    logic le;        // this cell holds a priority at or below the request's
    logic seen_ge;   // a used cell with priority at or above the request's is at or left
    logic seen_key;  // a used cell with the request's key is at or left
  } fwd_t;

  typedef struct packed {
    logic first_ge;
    logic first_key;
    logic peq;
  } cell_stat_t;

endpackage

// ===== rtl/kpwq_cell.sv =====
module kpwq_cell import kpwq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 cmp_en_i,
  input  req_t                 req_i,
  input  logic                 used_i,
  input  logic [PRIO_BITS-1:0] right_prio_i,
  input  cell_cmd_t            cmd_i,
  input  logic [KEY_BITS-1:0]  left_key_i,
  input  logic [PRIO_BITS-1:0] left_prio_i,
  input  logic [KEY_BITS-1:0]  right_key_i,
  input  fwd_t                 fwd_i,
  input  logic                 left_grp_i,
  input  logic                 grp_i,
  output fwd_t                 fwd_o,
  output logic                 grp_o,
  output cell_stat_t           stat_o,
  output logic [KEY_BITS-1:0]  key_o,
  output logic [PRIO_BITS-1:0] prio_o
);

  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [PRIO_BITS-1:0] prio_q, prio_d;
  logic le_q, ge_q, peq_q, keq_q, nbeq_q;
  logic first_key;

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    prio_q <= prio_d;
    if (cmp_en_i) begin
      le_q   <= used_i && (prio_q <= req_i.in_priority);
      ge_q   <= used_i && (prio_q >= req_i.in_priority);
      peq_q  <= used_i && (prio_q == req_i.in_priority);
      keq_q  <= used_i && (key_q == req_i.in_key);
      nbeq_q <= (prio_q == right_prio_i);
    end
  end

  assign first_key = keq_q && !fwd_i.seen_key;

  // grp: this cell lies in the run from the bumped entry back to its group's front
  assign grp_o = first_key || (grp_i && nbeq_q);

  assign fwd_o.le       = le_q;
  assign fwd_o.seen_ge  = fwd_i.seen_ge || ge_q;
  assign fwd_o.seen_key = fwd_i.seen_key || keq_q;

  assign stat_o.first_ge  = ge_q && !fwd_i.seen_ge;
  assign stat_o.first_key = first_key;
  assign stat_o.peq       = peq_q;

  always_comb begin
    key_d  = key_q;
    prio_d = prio_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (!le_q) begin
          if (fwd_i.le) begin
            key_d  = cmd_i.key;
            prio_d = cmd_i.prio;
          end else begin
            key_d  = left_key_i;
            prio_d = left_prio_i;
          end
        end
      end
      OP_BUMP: begin
        if (grp_o) begin
          if (left_grp_i) begin
            key_d  = left_key_i;
            prio_d = left_prio_i;
          end else begin
            key_d  = cmd_i.key;
            prio_d = cmd_i.prio;
          end
        end
      end
      OP_DELETE: begin
        if (fwd_o.seen_key) begin
          key_d  = right_key_i;
          prio_d = right_prio_i;
        end
      end
      default: ;
    endcase
  end

  assign key_o  = key_q;
  assign prio_o = prio_q;

endmodule

// ===== rtl/keyed_priority_work_queue.sv =====
// Channel   Valid        Stall        Payload
// request   in_valid_i   in_stall_o   in_req_i  (req_t)
// response  out_valid_o  out_stall_i  out_rsp_o (rsp_t)
//
// Per request, the accept edge registers per-cell compares; the execute edge
// runs the neighbor chains through the cell row, updates the cells and loads
// the response register. One request is in flight at a time.
// A finished response may wait in its register while the next request is taken;
// that request then executes once the response register frees up.
// Reset clears the entry count and handshake flags; cell contents are not reset.
module keyed_priority_work_queue import kpwq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic          pend_q, out_valid_q;
  req_t          req_q;
  rsp_t          rsp_q, rsp_d;
  logic [CW-1:0] count_q, count_d;
  logic          accept, fire;
  cell_cmd_t     cmd;

  logic [KEY_BITS-1:0]  key   [DEPTH];
  logic [PRIO_BITS-1:0] prio  [DEPTH];
  fwd_t                 fwd   [DEPTH];
  logic                 grp   [DEPTH];
  cell_stat_t           stat  [DEPTH];
  logic [DEPTH-1:0]     peq_vec;

  logic [KEY_BITS-1:0]  ge_key, hit_key;
  logic [PRIO_BITS-1:0] ge_prio, hit_prio;
  logic                 key_hit, ge_hit, has_room;
  logic [CW-1:0]        match_cnt;

  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = pend_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = pend_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]  lk, rk;
    logic [PRIO_BITS-1:0] lp, rp;
    fwd_t                 lf;
    logic                 lg, rg;

    if (i == 0) begin : g_first
      assign lk = '0;
      assign lp = '0;
      assign lf = '{le: 1'b1, seen_ge: 1'b0, seen_key: 1'b0};
      assign lg = 1'b0;
    end else begin : g_mid
      assign lk = key[i-1];
      assign lp = prio[i-1];
      assign lf = fwd[i-1];
      assign lg = grp[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rk = '0;
      assign rp = '0;
      assign rg = 1'b0;
    end else begin : g_inner
      assign rk = key[i+1];
      assign rp = prio[i+1];
      assign rg = grp[i+1];
    end

    kpwq_cell u_cell (
      .clk_i        (clk_i),
      .cmp_en_i     (accept),
      .req_i        (in_req_i),
      .used_i       (CW'(i) < count_q),
      .right_prio_i (rp),
      .cmd_i        (cmd),
      .left_key_i   (lk),
      .left_prio_i  (lp),
      .right_key_i  (rk),
      .fwd_i        (lf),
      .left_grp_i   (lg),
      .grp_i        (rg),
      .fwd_o        (fwd[i]),
      .grp_o        (grp[i]),
      .stat_o       (stat[i]),
      .key_o        (key[i]),
      .prio_o       (prio[i])
    );

    assign peq_vec[i] = stat[i].peq;
  end

  // one-hot selections out of the row
  always_comb begin
    ge_key   = '0;
    ge_prio  = '0;
    hit_key  = '0;
    hit_prio = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (stat[i].first_ge) begin
        ge_key  = ge_key | key[i];
        ge_prio = ge_prio | prio[i];
      end
      if (stat[i].first_key) begin
        hit_key  = hit_key | key[i];
        hit_prio = hit_prio | prio[i];
      end
    end
  end

  assign key_hit   = fwd[DEPTH-1].seen_key;
  assign ge_hit    = fwd[DEPTH-1].seen_ge;
  assign has_room  = count_q < CW'(DEPTH);
  assign match_cnt = CW'($countones(peq_vec));

  always_comb begin
    cmd.op    = OP_HOLD;
    cmd.key   = req_q.in_key;
    cmd.prio  = req_q.in_priority;
    count_d   = count_q;
    rsp_d     = '0;
    rsp_d.status = ST_MISS;
    case (req_q.mode)
      MODE_INSERT: begin
        if (has_room) begin
          cmd.op       = OP_INSERT;
          count_d      = count_q + CW'(1);
          rsp_d.status = ST_DONE;
        end else begin
          rsp_d.status = ST_FULL;
        end
      end
      MODE_FIND: begin
        if (ge_hit) begin
          rsp_d.status       = ST_DONE;
          rsp_d.found        = 1'b1;
          rsp_d.out_key      = ge_key;
          rsp_d.out_priority = ge_prio;
        end
      end
      MODE_PRESENT: begin
        if (key_hit) begin
          rsp_d.status = ST_DONE;
          rsp_d.found  = 1'b1;
        end
      end
      MODE_BUMP: begin
        cmd.key  = hit_key;
        cmd.prio = hit_prio;
        if (key_hit) begin
          cmd.op       = OP_BUMP;
          rsp_d.status = ST_DONE;
          rsp_d.found  = 1'b1;
        end
      end
      MODE_COUNT: begin
        rsp_d.status      = ST_DONE;
        rsp_d.match_count = CNT_BITS'(match_cnt);
      end
      MODE_DELETE: begin
        if (key_hit) begin
          cmd.op       = OP_DELETE;
          count_d      = count_q - CW'(1);
          rsp_d.status = ST_DONE;
          rsp_d.found  = 1'b1;
        end
      end
      MODE_CLEAR: begin
        count_d      = '0;
        rsp_d.status = ST_DONE;
      end
      default: ;
    endcase
    rsp_d.total_count = CNT_BITS'(count_d);
    if (!fire) begin
      cmd.op  = OP_HOLD;
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        pend_q <= 1'b1;
      end else if (fire) begin
        pend_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== rtl/kpwq_checker.sv =====
module kpwq_checker import kpwq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_rsp_o
);

  // one request in flight: the request side stalls right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in flight");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.found |-> out_rsp_o.status == ST_DONE)
    else $error("found without done status");

  a_zero_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.found |-> out_rsp_o.out_key == '0 && out_rsp_o.out_priority == '0)
    else $error("entry data on a response without a match");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == ST_FULL |-> out_rsp_o.total_count == CNT_BITS'(DEPTH))
    else $error("full reported below capacity");

endmodule

bind keyed_priority_work_queue kpwq_checker #(.DEPTH(DEPTH)) u_kpwq_checker (.*);

// ===== bench/kpwq_checker.sv =====
`timescale 1ns / 100ps

module kpwq_scoreboard import kpwq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  req_t        in_req_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  rsp_t        out_rsp_o,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned checked,
  output int unsigned full_rejects
);

  // shadow copy of the sorted entry list
  logic [KEY_BITS-1:0]  entry_key  [DEPTH];
  logic [PRIO_BITS-1:0] entry_prio [DEPTH];
  int unsigned          entry_cnt;
  rsp_t                 rsp_expected_q [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    checked      = 0;
    full_rejects = 0;
    entry_cnt    = 0;
  end

  function automatic int first_with_key(logic [KEY_BITS-1:0] key);
    for (int i = 0; i < entry_cnt; i++) begin
      if (entry_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic rsp_t queue_step(req_t r);
    rsp_t                 e;
    int                   i;
    int                   pos;
    int                   hit;
    int                   front;
    logic [KEY_BITS-1:0]  mk;
    logic [PRIO_BITS-1:0] mp;
    e = '0;
    e.status = ST_MISS;
    case (r.mode)
      MODE_INSERT: begin
        if (entry_cnt >= DEPTH) begin
          e.status = ST_FULL;
        end else begin
          // new entry lands behind all entries of equal or lower number
          pos = 0;
          while (pos < entry_cnt && entry_prio[pos] <= r.in_priority) pos++;
          for (i = entry_cnt; i > pos; i--) begin
            entry_key[i]  = entry_key[i-1];
            entry_prio[i] = entry_prio[i-1];
          end
          entry_key[pos]  = r.in_key;
          entry_prio[pos] = r.in_priority;
          entry_cnt++;
          e.status = ST_DONE;
        end
      end
      MODE_FIND: begin
        for (i = 0; i < entry_cnt; i++) begin
          if (entry_prio[i] >= r.in_priority) begin
            e.status       = ST_DONE;
            e.found        = 1'b1;
            e.out_key      = entry_key[i];
            e.out_priority = entry_prio[i];
            break;
          end
        end
      end
      MODE_PRESENT: begin
        if (first_with_key(r.in_key) >= 0) begin
          e.status = ST_DONE;
          e.found  = 1'b1;
        end
      end
      MODE_BUMP: begin
        hit = first_with_key(r.in_key);
        if (hit >= 0) begin
          mk    = entry_key[hit];
          mp    = entry_prio[hit];
          front = hit;
          while (front > 0 && entry_prio[front-1] == mp) front--;
          for (i = hit; i > front; i--) begin
            entry_key[i]  = entry_key[i-1];
            entry_prio[i] = entry_prio[i-1];
          end
          entry_key[front]  = mk;
          entry_prio[front] = mp;
          e.status = ST_DONE;
          e.found  = 1'b1;
        end
      end
      MODE_COUNT: begin
        for (i = 0; i < entry_cnt; i++) begin
          if (entry_prio[i] == r.in_priority) e.match_count++;
        end
        e.status = ST_DONE;
      end
      MODE_DELETE: begin
        hit = first_with_key(r.in_key);
        if (hit >= 0) begin
          for (i = hit; i + 1 < entry_cnt; i++) begin
            entry_key[i]  = entry_key[i+1];
            entry_prio[i] = entry_prio[i+1];
          end
          entry_cnt--;
          e.status = ST_DONE;
          e.found  = 1'b1;
        end
      end
      MODE_CLEAR: begin
        entry_cnt = 0;
        e.status  = ST_DONE;
      end
      default: ;
    endcase
    e.total_count = CNT_BITS'(entry_cnt);
    return e;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      entry_cnt = 0;
      rsp_expected_q.delete();
      pending = 0;
    end else begin
      // compare before predicting: a request never answers on its own accept edge
      if (out_valid_o && !out_stall_i) begin
        if (rsp_expected_q.size() == 0) begin
          $error("response with no request outstanding: %h", out_rsp_o);
          fail_count++;
        end else begin
          exp_rsp = rsp_expected_q.pop_front();
          compare_field("status", exp_rsp.status, out_rsp_o.status);
          compare_field("found", exp_rsp.found, out_rsp_o.found);
          compare_field("out_key", exp_rsp.out_key, out_rsp_o.out_key);
          compare_field("out_priority", exp_rsp.out_priority, out_rsp_o.out_priority);
          compare_field("match_count", exp_rsp.match_count, out_rsp_o.match_count);
          compare_field("total_count", exp_rsp.total_count, out_rsp_o.total_count);
          checked++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        exp_rsp = queue_step(in_req_i);
        if (exp_rsp.status == ST_FULL) full_rejects++;
        rsp_expected_q.push_back(exp_rsp);
      end
      pending = rsp_expected_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import kpwq_pkg::*;

  localparam logic [2:0]  MODE_UNUSED  = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned HOLD_AT      = 80;
  localparam int unsigned HOLD_CYCLES  = 300;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b1;
  req_t in_req_i    = '0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned full_rejects;
  int unsigned sent_cnt;
  int unsigned directed_cnt;

  logic [KEY_BITS-1:0] key_pool [6];

  keyed_priority_work_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  kpwq_scoreboard u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .full_rejects (full_rejects)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic req_t make_req(logic [2:0] mode, logic [KEY_BITS-1:0] key,
                                    logic [PRIO_BITS-1:0] prio);
    req_t r;
    r.mode        = mode;
    r.in_key      = key;
    r.in_priority = prio;
    return r;
  endfunction

  // fill phases lean on inserts so the queue runs full; drain phases lean on deletes
  function automatic req_t random_request(bit fill_phase);
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < (fill_phase ? 50 : 22))      r.mode = MODE_INSERT;
    else if (pick < (fill_phase ? 60 : 36)) r.mode = MODE_FIND;
    else if (pick < (fill_phase ? 68 : 48)) r.mode = MODE_PRESENT;
    else if (pick < (fill_phase ? 80 : 60)) r.mode = MODE_BUMP;
    else if (pick < (fill_phase ? 87 : 68)) r.mode = MODE_COUNT;
    else if (pick < 96)                     r.mode = MODE_DELETE;
    else if (pick < 98)                     r.mode = MODE_CLEAR;
    else                                    r.mode = MODE_UNUSED;
    r.in_key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 5)] : $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: r.in_priority = PRIO_BITS'($urandom_range(0, 3));
      6:                r.in_priority = '1;
      7:                r.in_priority = ~PRIO_BITS'(1);
      default:          r.in_priority = PRIO_BITS'($urandom_range(0, 255));
    endcase
    return r;
  endfunction

  task automatic send_req(req_t r);
    int unsigned gap;
    gap = ((sent_cnt / 50) % 4 == 1) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sent_cnt++;
  endtask

  // response side: random stall per response, one long hold to back the block up
  initial begin
    int unsigned rsp_cnt;
    int unsigned wait_cyc;
    rsp_cnt = 0;
    forever begin
      if (rsp_cnt == HOLD_AT) wait_cyc = HOLD_CYCLES;
      else if ((rsp_cnt / 50) % 4 == 2) wait_cyc = 0;
      else wait_cyc = $urandom_range(0, 16);
      if (wait_cyc > 0) begin
        @(negedge clk_i) out_stall_i <= 1'b1;
        repeat (wait_cyc - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      rsp_cnt++;
    end
  end

  initial begin
    int unsigned random_cnt;
    req_t        r;
    sent_cnt     = 0;
    random_cnt   = 0;
    key_pool[0]  = '0;
    key_pool[1]  = '1;
    key_pool[2]  = 32'h0000_0001;
    key_pool[3]  = 32'h8000_0000;
    key_pool[4]  = $urandom();
    key_pool[5]  = $urandom();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // empty queue: every lookup misses
    send_req(make_req(MODE_FIND, 32'd5, 8'd0));
    send_req(make_req(MODE_PRESENT, 32'd5, 8'd0));
    send_req(make_req(MODE_BUMP, 32'd5, 8'd0));
    send_req(make_req(MODE_DELETE, 32'd5, 8'd0));
    send_req(make_req(MODE_COUNT, 32'd0, 8'd0));
    send_req(make_req(MODE_UNUSED, '1, '1));
    // field extremes and a same-priority group with a duplicate key
    send_req(make_req(MODE_INSERT, '1, 8'd200));
    send_req(make_req(MODE_INSERT, '0, 8'd0));
    send_req(make_req(MODE_INSERT, 32'd1, 8'd7));
    send_req(make_req(MODE_INSERT, 32'd2, 8'd7));
    send_req(make_req(MODE_INSERT, 32'd3, 8'd7));
    send_req(make_req(MODE_INSERT, 32'd1, '1));
    send_req(make_req(MODE_FIND, '0, 8'd8));
    // bump from the back of the group, then again when already at the front
    send_req(make_req(MODE_BUMP, 32'd3, 8'd0));
    send_req(make_req(MODE_BUMP, 32'd3, 8'd0));
    send_req(make_req(MODE_COUNT, '0, 8'd7));
    // delete takes only the first copy of a key
    send_req(make_req(MODE_DELETE, 32'd1, 8'd0));
    send_req(make_req(MODE_PRESENT, 32'd1, 8'd0));
    send_req(make_req(MODE_DELETE, 32'd1, 8'd0));
    send_req(make_req(MODE_FIND, '0, 8'd201));
    send_req(make_req(MODE_FIND, '0, 8'd0));
    send_req(make_req(MODE_PRESENT, '0, 8'd0));
    send_req(make_req(MODE_CLEAR, '0, 8'd0));
    send_req(make_req(MODE_COUNT, '0, 8'd7));
    directed_cnt = sent_cnt;

    while (random_cnt < RANDOM_ITEMS) begin
      r = random_request((random_cnt / 60) % 2 == 0);
      send_req(r);
      if (r.mode != MODE_UNUSED) random_cnt++;
    end
    @(negedge clk_i) in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Ran %0d requests (%0d directed), %0d responses compared field by field.",
             sent_cnt, directed_cnt, checked);
    $display("Inserts refused on a full queue: %0d; one %0d-cycle response hold applied.",
             full_rejects, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== keyed_priority_work_queue.f =====
rtl/kpwq_pkg.sv
rtl/kpwq_cell.sv
rtl/keyed_priority_work_queue.sv
rtl/kpwq_checker.sv
bench/kpwq_checker.sv
bench/tb.sv
